[design/npf_pkg.sv]
`timescale 1ns / 1ps

package npf_pkg;

    localparam int DATA_W          = 32;
    localparam int SEC_ID_W        = 5;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int SECTIONS_DEF    = 32;

    // operation codes on the func field
    localparam logic FN_START = 1'b0;
    localparam logic FN_END   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // outcome of the stack step for one item
    typedef struct packed {
        t_status             status;
        logic                upd;   // successful end, statistics get updated
        logic [DATA_W-1:0]   dur;
    } t_stk_op;

    // per-section statistics record
    typedef struct packed {
        logic [DATA_W-1:0] total;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] peak;
        logic [DATA_W-1:0] peak_idx;
    } t_stats;

endpackage

[design/nested_section_profiler.sv]
`timescale 1ns / 1ps

// ch  | handshake       | payload fields
// ----+-----------------+----------------------------------------------------------------------
// in  | i_valid/o_stall | i_func, i_section_id, i_now
// out | o_valid/i_stall | o_status, o_duration, o_total, o_sample_count, o_max_duration, o_max_sample
//
// one transfer in per cycle while o_stall is low; a result passes through stage one and then the output register
// stage one does the stack step, the statistics ram's registered read feeds the output register
// back-to-back hits on one section or one stack entry come from bypass registers
// synchronous active-low reset clears control flops only, no clearing pass
// unwritten sections read as zero through per-section valid flags
// a stalled result holds the pipeline; o_stall rises only while both stages are full

module nested_section_profiler #(
    parameter int STACK_DEPTH = npf_pkg::STACK_DEPTH_DEF,
    parameter int SECTIONS    = npf_pkg::SECTIONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_func,
    input  logic [npf_pkg::SEC_ID_W-1:0]  i_section_id,
    input  logic [npf_pkg::DATA_W-1:0]    i_now,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [npf_pkg::DATA_W-1:0]    o_duration,
    output logic [npf_pkg::DATA_W-1:0]    o_total,
    output logic [npf_pkg::DATA_W-1:0]    o_sample_count,
    output logic [npf_pkg::DATA_W-1:0]    o_max_duration,
    output logic [npf_pkg::DATA_W-1:0]    o_max_sample
);
    import npf_pkg::*;

    localparam int SW    = $clog2(SECTIONS);
    localparam int TAB_N = 2 ** SEC_ID_W;

    typedef logic [SW-1:0] t_sec_tab [TAB_N];

    // section id folded into range by a counter that wraps at the section count
    function automatic t_sec_tab build_sec_tab();
        t_sec_tab tab;
        int       c;
        c = 0;
        for (int i = 0; i < TAB_N; i++) begin
            tab[i] = SW'(c);
            c = (c == SECTIONS - 1) ? 0 : c + 1;
        end
        return tab;
    endfunction

    localparam t_sec_tab SEC_TAB = build_sec_tab();

    logic            accept, adv, stats_we;
    logic [SW-1:0]   sec_in, stk_sec, stats_raddr;
    t_stk_op         stk_op;
    t_stats          stats;

    // stage one: stack outcome waiting on the statistics read
    logic            r_s1_valid;
    t_stk_op         r_s1_op;
    logic [SW-1:0]   r_s1_sec;

    // output register
    logic            r_out_valid;
    t_status         r_out_status;
    logic [DATA_W-1:0] r_out_dur;
    t_stats          r_out_stats;

    assign sec_in  = SEC_TAB[i_section_id];
    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !adv;
    assign accept  = i_valid && !o_stall;

    npf_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .SW          (SW)
    ) u_stack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_func   (i_func),
        .i_sec    (sec_in),
        .i_now    (i_now),
        .o_op     (stk_op),
        .o_sec    (stk_sec)
    );

    // while stage one holds, keep re-reading its section so the data stays current
    assign stats_raddr = accept ? stk_sec : r_s1_sec;
    assign stats_we    = r_s1_valid && adv && r_s1_op.upd;

    npf_stats #(
        .SECTIONS (SECTIONS),
        .SW       (SW)
    ) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_raddr (stats_raddr),
        .i_we    (stats_we),
        .i_waddr (r_s1_sec),
        .i_op    (r_s1_op),
        .o_stats (stats)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (adv) begin
                r_s1_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op  <= stk_op;
            r_s1_sec <= stk_sec;
        end
        if (adv && r_s1_valid) begin
            r_out_status <= r_s1_op.status;
            r_out_dur    <= r_s1_op.dur;
            r_out_stats  <= stats;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_duration     = r_out_dur;
    assign o_total        = r_out_stats.total;
    assign o_sample_count = r_out_stats.count;
    assign o_max_duration = r_out_stats.peak;
    assign o_max_sample   = r_out_stats.peak_idx;

`ifndef NO_ASSERTIONS
    a_dur_within_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> (o_duration <= o_max_duration))
        else $error("reported duration exceeds section maximum");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |->
            (o_duration == '0 && o_total == '0 && o_sample_count == '0))
        else $error("empty-stack result carries statistics");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted transfer lost before stage one");

    a_hold_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> (r_s1_valid && $stable(r_s1_sec)))
        else $error("stage one changed while held");
`endif

endmodule

[design/npf_ram.sv]
`timescale 1ns / 1ps

module npf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/npf_stack.sv]
`timescale 1ns / 1ps

module npf_stack #(
    parameter int STACK_DEPTH = npf_pkg::STACK_DEPTH_DEF,
    parameter int SW          = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_func,
    input  logic [SW-1:0]               i_sec,
    input  logic [npf_pkg::DATA_W-1:0]  i_now,
    output npf_pkg::t_stk_op            o_op,
    output logic [SW-1:0]               o_sec
);
    import npf_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = DATA_W + SW;
    localparam logic [DW-1:0] FULL_D = DW'(STACK_DEPTH);

    // top entry lives in flops, entries below it in the ram
    logic [DW-1:0]     r_depth, n_depth;
    logic [DATA_W-1:0] r_top_time;
    logic [SW-1:0]     r_top_sec;
    logic              r_fwd_hit;
    logic [EW-1:0]     r_fwd_data;

    logic              full, empty, push, pop, we;
    logic [AW-1:0]     waddr, raddr;
    logic [DW-1:0]     wr_pos, rd_pos;
    logic [EW-1:0]     wdata, ram_rdata, below;

    assign full  = (r_depth == FULL_D);
    assign empty = (r_depth == '0);
    assign push  = i_accept && (i_func == FN_START) && !full;
    assign pop   = i_accept && (i_func == FN_END) && !empty;

    always_comb begin
        priority if (push) begin
            n_depth = r_depth + DW'(1);
        end else if (pop) begin
            n_depth = r_depth - DW'(1);
        end else begin
            n_depth = r_depth;
        end
    end

    // old top spills into the ram on a push
    assign we     = push && !empty;
    assign wr_pos = r_depth - DW'(1);
    assign waddr  = wr_pos[AW-1:0];
    assign wdata  = {r_top_time, r_top_sec};

    // keep the entry under the next top prefetched
    assign rd_pos = (n_depth >= DW'(2)) ? (n_depth - DW'(2)) : '0;
    assign raddr  = rd_pos[AW-1:0];
    assign below  = r_fwd_hit ? r_fwd_data : ram_rdata;

    npf_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth   <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_depth   <= n_depth;
            r_fwd_hit <= we && (waddr == raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= wdata;
        if (push) begin
            r_top_time <= i_now;
            r_top_sec  <= i_sec;
        end else if (pop) begin
            r_top_time <= below[EW-1:SW];
            r_top_sec  <= below[SW-1:0];
        end
    end

    always_comb begin
        o_op.status = ST_OK;
        o_op.upd    = 1'b0;
        o_op.dur    = '0;
        o_sec       = i_sec;
        if (i_func == FN_START) begin
            o_op.status = full ? ST_FULL : ST_OK;
        end else begin
            o_sec = r_top_sec;
            if (empty) begin
                o_op.status = ST_EMPTY;
            end else begin
                o_op.upd = 1'b1;
                o_op.dur = i_now - r_top_time;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= FULL_D)
        else $error("stack depth beyond capacity");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_depth == $past(r_depth) + DW'(1))
        else $error("push did not grow the stack");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_depth == $past(r_depth) - DW'(1))
        else $error("pop did not shrink the stack");
`endif

endmodule

[design/npf_stats.sv]
`timescale 1ns / 1ps

module npf_stats #(
    parameter int SECTIONS = npf_pkg::SECTIONS_DEF,
    parameter int SW       = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SW-1:0]     i_raddr,
    input  logic              i_we,
    input  logic [SW-1:0]     i_waddr,
    input  npf_pkg::t_stk_op  i_op,
    output npf_pkg::t_stats   o_stats
);
    import npf_pkg::*;

    localparam int RW = $bits(t_stats);

    logic [SECTIONS-1:0] r_valid;
    logic                r_vld_rd;
    logic                r_byp_hit;
    t_stats              r_byp_data;

    logic [RW-1:0]       ram_rdata;
    t_stats              cur, nxt;

    npf_ram #(
        .WIDTH (RW),
        .DEPTH (SECTIONS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (nxt),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_vld_rd  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_vld_rd  <= r_valid[i_raddr];
            r_byp_hit <= i_we && (i_waddr == i_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= nxt;
    end

    // a never-written section reads as zero
    always_comb begin
        if (r_byp_hit) begin
            cur = r_byp_data;
        end else if (r_vld_rd) begin
            cur = t_stats'(ram_rdata);
        end else begin
            cur = '0;
        end
        nxt       = cur;
        nxt.total = cur.total + i_op.dur;
        nxt.count = cur.count + DATA_W'(1);
        if (i_op.dur > cur.peak) begin
            nxt.peak     = i_op.dur;
            nxt.peak_idx = cur.count;
        end
    end

    always_comb begin
        unique case (i_op.status)
            ST_OK:    o_stats = i_op.upd ? nxt : cur;
            ST_FULL:  o_stats = cur;
            ST_EMPTY: o_stats = '0;
            default:  o_stats = '0;
        endcase
    end

endmodule
